[hdl/xorshift_rng_register_device_macros.svh]
// Assertion macros used by the checker file.
`ifndef XORSHIFT_RNG_REGISTER_DEVICE_MACROS_SVH
`define XORSHIFT_RNG_REGISTER_DEVICE_MACROS_SVH

// Check the consequence in the same cycle as the trigger.
`define XRNG_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("xrng check failed");

// Check the consequence in the cycle after the trigger.
`define XRNG_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("xrng check failed");

`endif

[hdl/xrng_pkg.sv]
`default_nettype none

package xrng_pkg;

  localparam int ADDR_W = 6;
  localparam int DATA_W = 32;
  localparam int GEN_W  = 64;

  localparam int REG_WORDS_DEFAULT = 64;

  localparam logic [GEN_W-1:0] SEED = 64'h9e37_79b9_7f4a_7c15;
  localparam int SHIFT_A = 13;
  localparam int SHIFT_B = 7;
  localparam int SHIFT_C = 17;

  // Register map, word addresses
  localparam logic [ADDR_W-1:0] WORD_OUT0   = 6'h00;
  localparam logic [ADDR_W-1:0] WORD_OUT1   = 6'h01;
  localparam logic [ADDR_W-1:0] WORD_OUT2   = 6'h02;
  localparam logic [ADDR_W-1:0] WORD_OUT3   = 6'h03;
  localparam logic [ADDR_W-1:0] WORD_STATUS = 6'h04;

  localparam logic [DATA_W-1:0] READY_BIT = 32'h0000_0001;

  typedef enum logic {
    KIND_READ  = 1'b0,
    KIND_WRITE = 1'b1
  } kind_t;

endpackage

`default_nettype wire

[hdl/xrng_bus_if.sv]
`default_nettype none

// Access request channel
interface xrng_req_if;
  import xrng_pkg::*;

  logic              valid;
  logic              ready;
  kind_t             kind;
  logic [ADDR_W-1:0] word_address;
  logic [DATA_W-1:0] write_data;

  modport source (output valid, output kind, output word_address, output write_data,
                  input ready);
  modport sink   (input valid, input kind, input word_address, input write_data,
                  output ready);
endinterface

// Access response channel
interface xrng_rsp_if;
  import xrng_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;

  modport source (output valid, output read_data, input ready);
  modport sink   (input valid, input read_data, output ready);
endinterface

`default_nettype wire

[hdl/xrng_gen.sv]
`default_nettype none

module xrng_gen (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          advance,
  output logic [xrng_pkg::GEN_W-1:0]   next_value
);
  import xrng_pkg::*;

  logic [GEN_W-1:0] state;
  logic [GEN_W-1:0] s1;
  logic [GEN_W-1:0] s2;

  // Three shift-xor steps
  always_comb begin
    s1         = state ^ (state << SHIFT_A);
    s2         = s1 ^ (s1 >> SHIFT_B);
    next_value = s2 ^ (s2 << SHIFT_C);
  end

  // Hold the state, advance on request
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEED;
    end else if (advance) begin
      state <= next_value;
    end
  end

endmodule

`default_nettype wire

[hdl/xorshift_rng_register_device.sv]
`default_nettype none

// Random-number register device. Each request transfer is one 32-bit read
// or write of a word address; each gives exactly one response transfer,
// read data or zero for a write. The block takes a request every cycle while
// its response side is not stalled and answers in the next cycle: a single
// result register sits between the request and response sides, and a request
// is taken whenever that register is empty or its response is being taken in the same cycle. Reading word 0 or word 2
// advances a 64-bit xorshift generator (13/7/17, fixed seed at reset) and
// returns the low half, keeping the high half for word 1 or word 3. Word 4
// reads as 1. Words from 5 up to REG_WORDS-1 (at most 63) are read/write
// storage held in a memory with a per-word valid bit, so they read as zero
// right after reset with no clearing pass; other words read as zero and
// ignore writes. No request is taken while rst is high.
module xorshift_rng_register_device #(
  parameter int REG_WORDS = xrng_pkg::REG_WORDS_DEFAULT
) (
  input  wire          clk,
  input  wire          rst,
  xrng_req_if.sink     req,
  xrng_rsp_if.source   rsp
);
  import xrng_pkg::*;

  localparam int DEPTH  = (REG_WORDS < (1 << ADDR_W)) ? REG_WORDS : (1 << ADDR_W);
  localparam int IDX_W  = $clog2(DEPTH);

  logic             accept;
  logic             in_range;
  logic             gen_advance;
  logic [GEN_W-1:0] gen_next;
  logic [IDX_W-1:0] idx;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  word_valid;
  logic [DATA_W-1:0] mem_rd;
  logic              mem_hit;

  logic              rsp_valid;
  logic [DATA_W-1:0] res_data;
  logic [DATA_W-1:0] res_data_next;
  logic              res_from_mem;
  logic              res_from_mem_next;
  logic [DATA_W-1:0] pair_a_high;
  logic [DATA_W-1:0] pair_b_high;

  assign req.ready = ~rst & (~rsp_valid | rsp.ready);
  assign accept    = req.valid & req.ready;
  assign in_range  = {{(32-ADDR_W){1'b0}}, req.word_address} < 32'(DEPTH);
  assign idx       = req.word_address[IDX_W-1:0];

  xrng_gen u_gen (
    .clk        (clk),
    .rst        (rst),
    .advance    (gen_advance),
    .next_value (gen_next)
  );

  // Decode the access
  always_comb begin
    gen_advance       = 1'b0;
    res_data_next     = '0;
    res_from_mem_next = 1'b0;
    if (req.kind == KIND_READ) begin
      case (req.word_address)
        WORD_OUT0, WORD_OUT2: begin
          gen_advance   = accept;
          res_data_next = gen_next[DATA_W-1:0];
        end
        WORD_OUT1:   res_data_next = pair_a_high;
        WORD_OUT3:   res_data_next = pair_b_high;
        WORD_STATUS: res_data_next = READY_BIT;
        default:     res_from_mem_next = in_range;
      endcase
    end
  end

  // Keep the high halves of the two pairs
  always_ff @(posedge clk) begin
    if (rst) begin
      pair_a_high <= '0;
      pair_b_high <= '0;
    end else if (gen_advance) begin
      if (req.word_address == WORD_OUT0) begin
        pair_a_high <= gen_next[GEN_W-1:DATA_W];
      end else begin
        pair_b_high <= gen_next[GEN_W-1:DATA_W];
      end
    end
  end

  // Storage memory: write on a write transfer to a storage word, registered read on every accepted transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      if (req.kind == KIND_WRITE && in_range && req.word_address > WORD_STATUS) begin
        mem[idx] <= req.write_data;
      end
      mem_rd <= mem[idx];
    end
  end

  // Valid bit per storage word
  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= '0;
      mem_hit    <= 1'b0;
    end else if (accept) begin
      mem_hit <= word_valid[idx];
      if (req.kind == KIND_WRITE && in_range && req.word_address > WORD_STATUS) begin
        word_valid[idx] <= 1'b1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_data     <= res_data_next;
      res_from_mem <= res_from_mem_next;
    end
  end

  assign rsp.valid     = rsp_valid;
  assign rsp.read_data = res_from_mem ? (mem_hit ? mem_rd : '0) : res_data;

endmodule

`default_nettype wire

[hdl/xrng_checker.sv]
`default_nettype none

`include "xorshift_rng_register_device_macros.svh"

module xrng_checker (
  input wire                          clk,
  input wire                          rst,
  input wire                          req_valid,
  input wire                          req_ready,
  input wire                          req_kind,
  input wire [xrng_pkg::ADDR_W-1:0]   req_word_address,
  input wire                          rsp_valid,
  input wire                          rsp_ready,
  input wire [xrng_pkg::DATA_W-1:0]   rsp_read_data
);
  import xrng_pkg::*;

  logic req_xfer;
  assign req_xfer = req_valid & req_ready;

  // A stalled response holds its data
  `XRNG_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_read_data))

  // An empty result slot always takes a request
  `XRNG_ASSERT_NOW(a_ready_when_empty, clk, rst, !rsp_valid, req_ready)

  // A write answers zero on the next cycle
  `XRNG_ASSERT_NEXT(a_write_zero, clk, rst, req_xfer && req_kind == KIND_WRITE, rsp_valid && rsp_read_data == '0)

  // The status word reads as ready
  `XRNG_ASSERT_NEXT(a_status_ready, clk, rst, req_xfer && req_kind == KIND_READ && req_word_address == WORD_STATUS, rsp_valid && rsp_read_data == READY_BIT)

endmodule

bind xorshift_rng_register_device xrng_checker u_xrng_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .req_kind         (req.kind),
  .req_word_address (req.word_address),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_read_data    (rsp.read_data)
);

`default_nettype wire
